// ----- hw/rtl/svsc_pkg.sv -----
// Package for the stuck value sample checker: types, codes and double compare helpers.
package svsc_pkg;

  localparam int unsigned DefRowBits    = 16;
  localparam int unsigned DefColumnBits = 8;

  typedef enum logic [1:0] {
    IssueNan      = 2'd0,
    IssueInf      = 2'd1,
    IssueStale    = 2'd2,
    IssueConstant = 2'd3
  } issue_e;

  typedef enum logic [1:0] {
    RegStaleEnable    = 2'd0,
    RegConstantEnable = 2'd1,
    RegRunLimit       = 2'd2
  } reg_index_e;

  typedef struct packed {
    issue_e      code;
    logic [15:0] row;
    logic [7:0]  column;
    logic [15:0] run;
  } issue_t;

  typedef struct packed {
    logic        stale_enable;
    logic        constant_enable;
    logic [15:0] run_limit;
  } cfg_t;

  // Equality of two finite doubles: +0 and -0 compare equal.
  function automatic logic fp_eq(input logic [63:0] a, input logic [63:0] b);
    fp_eq = (a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0));
  endfunction

  // a < b for two finite doubles.
  function automatic logic fp_lt(input logic [63:0] a, input logic [63:0] b);
    logic res;
    res = 1'b0;
    if (fp_eq(a, b)) begin
      res = 1'b0;
    end else if (a[63] != b[63]) begin
      res = a[63];
    end else if (!a[63]) begin
      res = a[62:0] < b[62:0];
    end else begin
      res = a[62:0] > b[62:0];
    end
    fp_lt = res;
  endfunction

endpackage

// ----- hw/rtl/svsc_cfg_regs.sv -----
// Configuration register file of the stuck value sample checker.
module svsc_cfg_regs
  import svsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{stale_enable: 1'b1, constant_enable: 1'b1, run_limit: 16'd16};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegStaleEnable:    cfg_q.stale_enable    <= cfg_data_i[0];
        RegConstantEnable: cfg_q.constant_enable <= cfg_data_i[0];
        RegRunLimit:       cfg_q.run_limit       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/svsc_core.sv -----
// Per-sample checking datapath: column state update and issue generation.
module svsc_core
  import svsc_pkg::*;
#(
  parameter int unsigned ROW_BITS    = DefRowBits,
  parameter int unsigned COLUMN_BITS = DefColumnBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        step_i,
  input  logic [63:0] sample_i,
  input  logic        last_i,
  output logic        first_vld_o,
  output issue_t      first_o,
  output logic        second_vld_o,
  output issue_t      second_o
);

  logic [ROW_BITS-1:0]    row_q;
  logic [COLUMN_BITS-1:0] col_q;
  logic [63:0]            prev_q, min_q, max_q;
  logic                   have_prev_q, seen_q, reported_q;
  logic [15:0]            rep_q;

  logic        special, is_nan, repeat_hit, fire, konst;
  logic [63:0] min_n, max_n;
  logic [15:0] rep_n;
  logic [15:0] row16;
  logic [7:0]  col8;

  always_comb begin
    special    = (sample_i[62:52] == 11'h7FF);
    is_nan     = special && (sample_i[51:0] != 52'd0);
    min_n      = min_q;
    max_n      = max_q;
    if (!special) begin
      if (!seen_q) begin
        min_n = sample_i;
        max_n = sample_i;
      end else begin
        if (fp_lt(sample_i, min_q)) min_n = sample_i;
        if (fp_lt(max_q, sample_i)) max_n = sample_i;
      end
    end
    repeat_hit = have_prev_q && fp_eq(sample_i, prev_q);
    rep_n      = rep_q;
    if (!special && cfg_i.stale_enable) begin
      if (repeat_hit) rep_n = (rep_q == 16'hFFFF) ? rep_q : rep_q + 16'd1;
      else rep_n = 16'd0;
    end
    fire  = !special && cfg_i.stale_enable && repeat_hit &&
            (rep_n == cfg_i.run_limit) && !reported_q;
    konst = last_i && cfg_i.constant_enable && (seen_q || !special) &&
            (row_q != '0) && fp_eq(min_n, max_n);
    row16 = 16'(row_q);
    col8  = 8'(col_q);
  end

  always_comb begin
    first_vld_o  = special || fire || konst;
    second_vld_o = (special || fire) && konst;
    first_o.column  = col8;
    second_o        = '{code: IssueConstant, row: 16'd0, column: col8, run: 16'd0};
    if (special) begin
      first_o.code = is_nan ? IssueNan : IssueInf;
      first_o.row  = row16;
      first_o.run  = 16'd0;
    end else if (fire) begin
      first_o.code = IssueStale;
      first_o.row  = row16;
      first_o.run  = rep_n;
    end else begin
      first_o.code = IssueConstant;
      first_o.row  = 16'd0;
      first_o.run  = 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; prev_q <= '0; min_q <= '0; max_q <= '0;
      have_prev_q <= 1'b0; seen_q <= 1'b0; reported_q <= 1'b0; rep_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        row_q <= '0; prev_q <= '0; min_q <= '0; max_q <= '0;
        have_prev_q <= 1'b0; seen_q <= 1'b0; reported_q <= 1'b0; rep_q <= '0;
        if (col_q != '1) col_q <= col_q + 1'b1;
      end else begin
        if (row_q != '1) row_q <= row_q + 1'b1;
        min_q <= min_n;
        max_q <= max_n;
        rep_q <= rep_n;
        if (fire) reported_q <= 1'b1;
        if (!special) begin
          prev_q <= sample_i; have_prev_q <= 1'b1; seen_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/svsc_out_buf.sv -----
// Two-entry result queue that drains into the output stream.
module svsc_out_buf
  import svsc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  logic   a_vld_i,
  input  issue_t a_i,
  input  logic   b_vld_i,
  input  issue_t b_i,
  output logic   room_o,
  output logic   vld_o,
  output issue_t data_o,
  output logic   final_o,
  input  logic   ready_i
);

  issue_t     e0_q, e1_q;
  logic       f0_q, f1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = vld_o && ready_i;
  assign vld_o   = (cnt_q != 2'd0);
  assign data_o  = e0_q;
  assign final_o = f0_q;
  // Room for two entries once the head leaves.
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i && a_vld_i) begin
      cnt_q <= b_vld_i ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && a_vld_i) begin
      e0_q <= a_i; f0_q <= !b_vld_i;
      e1_q <= b_i; f1_q <= 1'b1;
    end else if (pop) begin
      e0_q <= e1_q; f0_q <= f1_q;
    end
  end

endmodule

// ----- hw/rtl/stuck_value_sample_checker_top.sv -----
// Top level of the stuck value sample checker.
//
// Checks one IEEE double sample per transaction, at up to one transaction per clock: the
// checking datapath is combinational and feeds a two-entry result queue. An item is
// accepted whenever the result queue has room for its up to two issues: input is held
// off while one issue waits and the output side does not take it, and while a queued
// pair of issues is still being drained. Issues appear on the output in the cycle after
// the causing sample is accepted; NaN, infinite and stale issues come before a
// constant-column issue of the same sample.
module stuck_value_sample_checker_top
  import svsc_pkg::*;
#(
  parameter int unsigned ROW_BITS    = DefRowBits,
  parameter int unsigned COLUMN_BITS = DefColumnBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // sample_bits
  input  logic        s_axis_tlast,   // column_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // issue_code, row_index, column_index, run_length, pad
  output logic        m_axis_tlast,   // final_issue
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t   cfg;
  logic   step, a_vld, b_vld, room;
  issue_t a_iss, b_iss, o_iss;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;
  assign step          = s_axis_tvalid && room;

  svsc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  svsc_core #(.ROW_BITS(ROW_BITS), .COLUMN_BITS(COLUMN_BITS)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .step_i(step), .sample_i(s_axis_tdata),
    .last_i(s_axis_tlast), .first_vld_o(a_vld), .first_o(a_iss),
    .second_vld_o(b_vld), .second_o(b_iss)
  );

  svsc_out_buf u_buf (
    .clk_i, .rst_ni, .push_i(step), .a_vld_i(a_vld), .a_i(a_iss), .b_vld_i(b_vld),
    .b_i(b_iss), .room_o(room), .vld_o(m_axis_tvalid), .data_o(o_iss),
    .final_o(m_axis_tlast), .ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {6'd0, o_iss.run, o_iss.column, o_iss.row, o_iss.code};

`ifndef ASSERT_OFF
  a_second_implies_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld |-> a_vld) else $error("second issue without first");
  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input accepted while a pair is queued");
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && a_vld) |=> m_axis_tvalid) else $error("issue lost");
`endif

endmodule
